[hw/rtl/nbl_pkg.sv]
`default_nettype none

package nbl_pkg;

    localparam int MAX_DEPTH_DEF = 32;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 4;
    localparam int NDEP_W  = 6;

    localparam logic [EVENT_W-1:0] EV_SKIP      = 4'd0;
    localparam logic [EVENT_W-1:0] EV_WORD      = 4'd1;
    localparam logic [EVENT_W-1:0] EV_BLK_OPEN  = 4'd2;
    localparam logic [EVENT_W-1:0] EV_BLK_CLOSE = 4'd3;
    localparam logic [EVENT_W-1:0] EV_LST_OPEN  = 4'd4;
    localparam logic [EVENT_W-1:0] EV_LST_CLOSE = 4'd5;
    localparam logic [EVENT_W-1:0] EV_LINE_END  = 4'd6;
    localparam logic [EVENT_W-1:0] EV_ACCEPT    = 4'd7;
    localparam logic [EVENT_W-1:0] EV_ERROR     = 4'd8;

    localparam logic [1:0] MODE_LINE  = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_NEXT  = 2'd2;
    localparam logic [1:0] MODE_WORD  = 2'd3;

    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_LIST  = 1'b1;

    typedef struct packed {
        logic [EVENT_W-1:0] event_kind;
        logic               starts_line;
        logic               starts_word;
        logic               ends_word;
        logic [NDEP_W-1:0]  nest_depth;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
        logic kind;
    } t_stk_op;

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_NL);
    endfunction

    function automatic logic is_word(input logic [BYTE_W-1:0] b);
        return (b != CH_NUL) && !is_space(b) && (b != CH_SEMI) &&
               (b != CH_LBRACE) && (b != CH_RBRACE) &&
               (b != CH_LBRACK) && (b != CH_RBRACK);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/nbl_intf.sv]
`default_nettype none

interface nbl_in_if;
    logic                        valid;
    logic                        ready;
    logic [nbl_pkg::BYTE_W-1:0]  text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface nbl_out_if;
    logic                        valid;
    logic                        ready;
    logic [nbl_pkg::EVENT_W-1:0] event_kind;
    logic                        starts_line;
    logic                        starts_word;
    logic                        ends_word;
    logic [nbl_pkg::NDEP_W-1:0]  nest_depth;

    modport source (output valid, output event_kind, output starts_line,
                    output starts_word, output ends_word, output nest_depth,
                    input ready);
    modport sink   (input valid, input event_kind, input starts_line,
                    input starts_word, input ends_word, input nest_depth,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/nbl_cell.sv]
`default_nettype none

module nbl_cell (
    input  wire logic             i_clk,
    input  wire nbl_pkg::t_stk_op i_op,
    input  wire logic             i_from_upper,
    input  wire logic             i_from_lower,
    output logic                  o_bit
);
    import nbl_pkg::*;

    logic r_bit;
    logic n_bit;

    always_comb begin
        priority if (i_op.push) begin
            n_bit = i_from_upper;
        end else if (i_op.pop) begin
            n_bit = i_from_lower;
        end else begin
            n_bit = r_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

`default_nettype wire

[hw/rtl/nbl_ctrl.sv]
`default_nettype none

module nbl_ctrl #(
    parameter int MAX_DEPTH = nbl_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_acc,
    input  wire logic [nbl_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_top_bit,
    output nbl_pkg::t_stk_op                o_op,
    output nbl_pkg::t_result                o_res
);
    import nbl_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int EW = DW + NDEP_W;

    logic [1:0]    r_mode;
    logic [1:0]    n_mode;
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic          r_failed;
    logic          n_failed;

    logic          w_top_list;
    logic          w_can_push;
    logic [1:0]    w_mode_e;
    logic          w_done;
    logic          w_start;
    logic [EW-1:0] w_dep_ext;
    t_stk_op       w_op;
    t_result       w_res;

    assign w_top_list = (r_depth != '0) && i_top_bit;
    assign w_can_push = r_depth < DW'(MAX_DEPTH);

    always_comb begin
        w_res.event_kind  = EV_SKIP;
        w_res.starts_line = 1'b0;
        w_res.starts_word = 1'b0;
        w_res.ends_word   = 1'b0;
        w_op              = '0;
        n_mode            = r_mode;
        n_depth           = r_depth;
        n_failed          = r_failed;
        w_mode_e          = r_mode;
        w_done            = 1'b0;
        w_start           = 1'b0;

        priority if (i_byte == CH_NUL) begin
            w_res.event_kind = (!r_failed && (r_mode == MODE_LINE) && (r_depth == '0)) ?
                               EV_ACCEPT : EV_ERROR;
            n_mode   = MODE_LINE;
            n_depth  = '0;
            n_failed = 1'b0;
        end else if (r_failed) begin
            w_res.event_kind = EV_ERROR;
        end else begin
            if (r_mode == MODE_WORD) begin
                if (is_word(i_byte)) begin
                    w_res.event_kind = EV_WORD;
                    w_done           = 1'b1;
                end else begin
                    w_res.ends_word = 1'b1;
                    w_mode_e        = MODE_NEXT;
                end
            end
            if (!w_done && is_space(i_byte)) begin
                w_res.event_kind = EV_SKIP;
                w_done           = 1'b1;
            end
            if (!w_done) begin
                unique case (w_mode_e)
                    MODE_LINE: begin
                        priority if (i_byte == CH_SEMI || i_byte == CH_RBRACK) begin
                            w_res.event_kind = EV_ERROR;
                        end else if (i_byte == CH_RBRACE) begin
                            if (r_depth == '0 || w_top_list) begin
                                w_res.event_kind = EV_ERROR;
                            end else begin
                                w_op.pop         = 1'b1;
                                n_depth          = r_depth - DW'(1);
                                w_mode_e         = MODE_NEXT;
                                w_res.event_kind = EV_BLK_CLOSE;
                            end
                        end else begin
                            w_res.starts_line = 1'b1;
                            w_start           = 1'b1;
                        end
                    end
                    MODE_FIRST: begin
                        if (i_byte == CH_RBRACE || i_byte == CH_RBRACK ||
                            i_byte == CH_SEMI) begin
                            w_res.event_kind = EV_ERROR;
                        end else begin
                            w_start = 1'b1;
                        end
                    end
                    MODE_NEXT, MODE_WORD: begin
                        priority if (i_byte == CH_RBRACE) begin
                            w_res.event_kind = EV_ERROR;
                        end else if (i_byte == CH_SEMI) begin
                            if (w_top_list) begin
                                w_res.event_kind = EV_ERROR;
                            end else begin
                                w_mode_e         = MODE_LINE;
                                w_res.event_kind = EV_LINE_END;
                            end
                        end else if (i_byte == CH_RBRACK) begin
                            if (!w_top_list) begin
                                w_res.event_kind = EV_ERROR;
                            end else begin
                                w_op.pop         = 1'b1;
                                n_depth          = r_depth - DW'(1);
                                w_mode_e         = MODE_NEXT;
                                w_res.event_kind = EV_LST_CLOSE;
                            end
                        end else begin
                            w_start = 1'b1;
                        end
                    end
                    default: begin
                        w_res.event_kind = EV_ERROR;
                    end
                endcase
            end
            if (w_start) begin
                priority if (i_byte == CH_LBRACE || i_byte == CH_LBRACK) begin
                    if (w_can_push) begin
                        w_op.push        = 1'b1;
                        w_op.kind        = (i_byte == CH_LBRACK) ? KIND_LIST : KIND_BLOCK;
                        n_depth          = r_depth + DW'(1);
                        w_mode_e         = (i_byte == CH_LBRACK) ? MODE_FIRST : MODE_LINE;
                        w_res.event_kind = (i_byte == CH_LBRACK) ? EV_LST_OPEN : EV_BLK_OPEN;
                    end else begin
                        w_res.event_kind = EV_ERROR;
                    end
                end else if (is_word(i_byte)) begin
                    w_res.starts_word = 1'b1;
                    w_mode_e          = MODE_WORD;
                    w_res.event_kind  = EV_WORD;
                end else begin
                    w_res.event_kind = EV_ERROR;
                end
            end
            n_mode = w_mode_e;
            if (w_res.event_kind == EV_ERROR) begin
                n_failed          = 1'b1;
                w_res.starts_line = 1'b0;
                w_res.starts_word = 1'b0;
                w_res.ends_word   = 1'b0;
            end
        end
        w_dep_ext        = EW'(n_depth);
        w_res.nest_depth = w_dep_ext[NDEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LINE;
            r_depth  <= '0;
            r_failed <= 1'b0;
        end else if (i_acc) begin
            r_mode   <= n_mode;
            r_depth  <= n_depth;
            r_failed <= n_failed;
        end
    end

    assign o_op.push = w_op.push && i_acc;
    assign o_op.pop  = w_op.pop && i_acc;
    assign o_op.kind = w_op.kind;
    assign o_res     = w_res;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_DEPTH))
        else $error("nesting depth beyond stack size");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_byte == CH_NUL) |=> (r_depth == '0 && !r_failed && r_mode == MODE_LINE))
        else $error("end of text did not return parser to idle");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_op.push && o_op.pop))
        else $error("stack push and pop in same cycle");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_failed && i_byte != CH_NUL) |-> (o_res.event_kind == EV_ERROR &&
            $stable(r_depth)))
        else $error("error state not held");
`endif

endmodule

`default_nettype wire

[hw/rtl/nbl_obuf.sv]
`default_nettype none

module nbl_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire nbl_pkg::t_result i_data,
    output logic                  o_ready,
    nbl_out_if.source             o_res
);
    import nbl_pkg::*;

    logic    r_v0;
    logic    r_v1;
    logic    n_v0;
    logic    n_v1;
    t_result r_d0;
    t_result r_d1;
    t_result n_d0;
    t_result n_d1;
    logic    w_pop;

    assign w_pop   = r_v0 && o_res.ready;
    assign o_ready = !r_v1;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        priority if (w_pop && r_v1) begin
            n_d0 = r_d1;
            n_v1 = i_push;
            n_d1 = i_data;
        end else if (w_pop) begin
            n_v0 = i_push;
            n_d0 = i_data;
        end else if (i_push && !r_v0) begin
            n_v0 = 1'b1;
            n_d0 = i_data;
        end else if (i_push) begin
            n_v1 = 1'b1;
            n_d1 = i_data;
        end else begin
            n_v0 = r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_res.valid       = r_v0;
    assign o_res.event_kind  = r_d0.event_kind;
    assign o_res.starts_line = r_d0.starts_line;
    assign o_res.starts_word = r_d0.starts_word;
    assign o_res.ends_word   = r_d0.ends_word;
    assign o_res.nest_depth  = r_d0.nest_depth;

`ifndef SYNTHESIS
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("second entry valid without head entry");
`endif

endmodule

`default_nettype wire

[hw/rtl/nested_block_list_syntax_parser.sv]
// Channel    Dir  Payload                                                   Flow
// i_text     in   text_byte[7:0]                                            valid/ready
// o_result   out  event_kind[3:0] starts_line starts_word ends_word         valid/ready
//                 nest_depth[5:0]
//
// One byte per cycle while the output buffer has room; each result is registered in the output buffer.
// Parse state updates and the context stack cell row shift in the accept cycle.
// Two-entry output buffer: input stays ready while one result waits.
// Synchronous active-low reset clears mode, depth, error flag and buffer.
`default_nettype none

module nested_block_list_syntax_parser #(
    parameter int MAX_DEPTH = nbl_pkg::MAX_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nbl_in_if.sink     i_text,
    nbl_out_if.source  o_result
);
    import nbl_pkg::*;

    logic    w_ready;
    logic    w_acc;
    t_stk_op w_op;
    t_result w_res;
    logic    w_bit [MAX_DEPTH];

    assign i_text.ready = w_ready;
    assign w_acc        = i_text.valid && w_ready;

    nbl_ctrl #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_acc),
        .i_byte    (i_text.text_byte),
        .i_top_bit (w_bit[0]),
        .o_op      (w_op),
        .o_res     (w_res)
    );

    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        logic w_up;
        logic w_dn;
        if (g == 0) begin : g_head
            assign w_up = w_op.kind;
        end else begin : g_mid
            assign w_up = w_bit[g-1];
        end
        if (g == MAX_DEPTH - 1) begin : g_tail
            assign w_dn = 1'b0;
        end else begin : g_body
            assign w_dn = w_bit[g+1];
        end
        nbl_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_from_upper (w_up),
            .i_from_lower (w_dn),
            .o_bit        (w_bit[g])
        );
    end

    nbl_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_res),
        .o_ready (w_ready),
        .o_res   (o_result)
    );

endmodule

`default_nettype wire
